@@ hdl/spq_pkg.sv @@
package spq_pkg;

  // request codes carried in the action bit
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // result codes
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } spq_status_t;

  // width of the reported entry count
  localparam int COUNT_BITS = 5;

  // per-cycle operation broadcast along the chain
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_op_t;

endpackage

@@ hdl/spq_in_if.sv @@
interface spq_in_if #(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic [KEY_BITS-1:0]     entry_key;
  logic [PAYLOAD_BITS-1:0] entry_payload;

  modport source (output valid, action, entry_key, entry_payload, input ready);
  modport sink   (input valid, action, entry_key, entry_payload, output ready);
endinterface

@@ hdl/spq_out_if.sv @@
interface spq_out_if #(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
);
  logic                              valid;
  logic                              ready;
  spq_pkg::spq_status_t              status;
  logic [KEY_BITS-1:0]               out_key;
  logic [PAYLOAD_BITS-1:0]           out_payload;
  logic [spq_pkg::COUNT_BITS-1:0]    count;

  modport source (output valid, status, out_key, out_payload, count, input ready);
  modport sink   (input valid, status, out_key, out_payload, count, output ready);
endinterface

@@ hdl/spq_cell.sv @@
module spq_cell #(
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input  logic                    clk,
  input  spq_pkg::spq_op_t        op,
  input  logic [KEY_BITS-1:0]     new_key,
  input  logic [PAYLOAD_BITS-1:0] new_payload,
  input  logic                    occupied,
  input  logic                    prev_ge,
  input  logic [KEY_BITS-1:0]     prev_key,
  input  logic [PAYLOAD_BITS-1:0] prev_payload,
  input  logic [KEY_BITS-1:0]     next_key,
  input  logic [PAYLOAD_BITS-1:0] next_payload,
  output logic                    ge,
  output logic [KEY_BITS-1:0]     key,
  output logic [PAYLOAD_BITS-1:0] payload
);

  // held entry stays ahead of the new one when its key is not smaller
  assign ge = occupied && (key >= new_key);

  // insert: keep, take the new word at the boundary, or shift down from the
  // neighbour above; remove: shift up from the neighbour below
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (!ge) begin
        if (prev_ge) begin
          key     <= new_key;
          payload <= new_payload;
        end else begin
          key     <= prev_key;
          payload <= prev_payload;
        end
      end
    end else if (op.rem) begin
      key     <= next_key;
      payload <= next_payload;
    end
  end

endmodule

@@ hdl/sorted_priority_queue_core.sv @@
// Bounded priority queue held as a row of CAPACITY cells in key order, the
// largest key at the head; equal keys leave in arrival order. Every request
// word (insert or remove) gives exactly one response word carrying a status,
// the removed entry on a successful remove (zero otherwise) and the entry
// count after the step. One request is taken per cycle unless a response
// waits unaccepted: the new key is compared in every cell at once and the
// whole row shifts by one place in the same cycle, and the response follows
// in the next cycle from the output register. A new request is taken in the
// same cycle as the waiting response is taken; while a response waits
// unaccepted, requests are held off. An insert on a full queue and a remove
// on an empty queue leave the contents untouched.
module sorted_priority_queue_core #(
  parameter int CAPACITY     = 16,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input logic    clk,
  input logic    rst,
  spq_in_if.sink   cmd,
  spq_out_if.source rsp
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]           entry_count;
  logic                    accept;
  logic                    is_full;
  logic                    is_empty;
  spq_pkg::spq_op_t        op;

  logic [CAPACITY-1:0]     cell_ge;
  logic [CAPACITY-1:0]     cell_occ;
  logic [KEY_BITS-1:0]     cell_key [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_pay [CAPACITY];

  // output register frees itself when taken, so input is held only on stall
  assign cmd.ready = !rsp.valid || rsp.ready;
  assign accept    = cmd.valid && cmd.ready;
  assign is_full   = (entry_count == CW'(CAPACITY));
  assign is_empty  = (entry_count == '0);

  always_comb begin
    op.ins = accept && (cmd.action == spq_pkg::ACT_INSERT) && !is_full;
    op.rem = accept && (cmd.action == spq_pkg::ACT_REMOVE) && !is_empty;
  end

  // the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    p_ge;
    logic [KEY_BITS-1:0]     p_key;
    logic [PAYLOAD_BITS-1:0] p_pay;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] n_pay;

    assign cell_occ[i] = (entry_count > CW'(i));

    if (i == 0) begin : g_head
      assign p_ge  = 1'b1;
      assign p_key = cell_key[i];
      assign p_pay = cell_pay[i];
    end else begin : g_mid
      assign p_ge  = cell_ge[i-1];
      assign p_key = cell_key[i-1];
      assign p_pay = cell_pay[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign n_key = cell_key[i];
      assign n_pay = cell_pay[i];
    end else begin : g_body
      assign n_key = cell_key[i+1];
      assign n_pay = cell_pay[i+1];
    end

    spq_cell #(
      .KEY_BITS     (KEY_BITS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk          (clk),
      .op           (op),
      .new_key      (cmd.entry_key),
      .new_payload  (cmd.entry_payload),
      .occupied     (cell_occ[i]),
      .prev_ge      (p_ge),
      .prev_key     (p_key),
      .prev_payload (p_pay),
      .next_key     (n_key),
      .next_payload (n_pay),
      .ge           (cell_ge[i]),
      .key          (cell_key[i]),
      .payload      (cell_pay[i])
    );
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (op.ins) begin
      entry_count <= entry_count + CW'(1);
    end else if (op.rem) begin
      entry_count <= entry_count - CW'(1);
    end
  end

  // response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // response word
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cmd.action == spq_pkg::ACT_INSERT) begin
        rsp.count       <= spq_pkg::COUNT_BITS'(op.ins ? entry_count + CW'(1) : entry_count);
        rsp.out_key     <= '0;
        rsp.out_payload <= '0;
        rsp.status      <= is_full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
      end else begin
        rsp.count <= spq_pkg::COUNT_BITS'(op.rem ? entry_count - CW'(1) : entry_count);
        if (is_empty) begin
          rsp.status      <= spq_pkg::STATUS_EMPTY;
          rsp.out_key     <= '0;
          rsp.out_payload <= '0;
        end else begin
          rsp.status      <= spq_pkg::STATUS_OK;
          rsp.out_key     <= cell_key[0];
          rsp.out_payload <= cell_pay[0];
        end
      end
    end
  end

endmodule

@@ hdl/spq_checker.sv @@
module spq_checker #(
  parameter int CAPACITY     = 16,
  parameter int KEY_BITS     = 16,
  parameter int PAYLOAD_BITS = 16
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           cmd_valid,
  input logic                           cmd_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input spq_pkg::spq_status_t           rsp_status,
  input logic [KEY_BITS-1:0]            rsp_key,
  input logic [PAYLOAD_BITS-1:0]        rsp_payload,
  input logic [spq_pkg::COUNT_BITS-1:0] rsp_count
);

  // every accepted request word shows a response in the next cycle
  a_rsp_follows: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> rsp_valid)
    else $error("accepted request without response");

  // a remove on an empty queue reports nothing and an empty queue
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == spq_pkg::STATUS_EMPTY) |->
      (rsp_key == '0 && rsp_payload == '0 && rsp_count == '0))
    else $error("empty status with stale data");

  // a refused insert happens only on a full queue
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_status == spq_pkg::STATUS_FULL) |->
      (rsp_count == spq_pkg::COUNT_BITS'(CAPACITY) && rsp_key == '0 && rsp_payload == '0))
    else $error("full status with wrong count or data");

  // a waiting response holds still
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_status) && $stable(rsp_count) && $stable(rsp_key)))
    else $error("stalled response changed");

endmodule

bind sorted_priority_queue_core spq_checker #(
  .CAPACITY     (CAPACITY),
  .KEY_BITS     (KEY_BITS),
  .PAYLOAD_BITS (PAYLOAD_BITS)
) u_spq_checker (
  .clk         (clk),
  .rst         (rst),
  .cmd_valid   (cmd.valid),
  .cmd_ready   (cmd.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_status  (rsp.status),
  .rsp_key     (rsp.out_key),
  .rsp_payload (rsp.out_payload),
  .rsp_count   (rsp.count)
);
